// ===== src/packet_checksum_crc32c_adler32_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet checksum block
// Shorthand for clocked properties with the usual reset qualifier.
// ----------------------------------------------------------------------------
`ifndef PACKET_CHECKSUM_CRC32C_ADLER32_MACROS_SVH
`define PACKET_CHECKSUM_CRC32C_ADLER32_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PCC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcc assertion failed");

// Consequent must hold in the cycle after the antecedent
`define PCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcc assertion failed");

`endif

// ===== src/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Types, constants and the CRC32C table function shared by the checksum block.
// ----------------------------------------------------------------------------
package pcc_pkg;

	localparam int unsigned LEN_W = 13;

	localparam logic [31:0]      CRC_POLY  = 32'h82F6_3B78;
	localparam logic [31:0]      CRC_INIT  = 32'hFFFF_FFFF;
	localparam logic [16:0]      ADLER_MOD = 17'd65521;
	localparam logic [LEN_W-1:0] LEN_SAT   = 13'd8191;
	localparam logic [LEN_W-1:0] MIN_RESET = 13'd16;
	localparam logic [LEN_W-1:0] MAX_RESET = 13'd5552;

	// Configuration register indexes
	localparam logic [1:0] CFG_IDX_TYPE = 2'd0;
	localparam logic [1:0] CFG_IDX_MIN  = 2'd1;
	localparam logic [1:0] CFG_IDX_MAX  = 2'd2;

	// Checksum selection codes
	localparam logic CK_CRC32C = 1'b0;
	localparam logic CK_ADLER  = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic [31:0]      checksum_value;
		logic             checksum_match;
		logic             length_in_range;
		logic             length_aligned;
		logic             packet_good;
		logic [LEN_W-1:0] packet_length;
	} res_t;

	// Classified byte passed from front to back
	typedef struct packed {
		logic [7:0]       data_byte;
		logic             field_en;
		logic [1:0]       field_sel;
		logic             last_byte;
		logic [LEN_W-1:0] packet_length;
	} cls_t;

	typedef struct packed {
		logic             checksum_type;
		logic [LEN_W-1:0] min_length;
		logic [LEN_W-1:0] max_length;
	} cfg_t;

	// Reflected CRC32C table entry for one index byte
	function automatic logic [31:0] crc_table(input logic [7:0] idx);
		logic [31:0] c;
		c = {24'd0, idx};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/pcc_fifo.sv =====
// ----------------------------------------------------------------------------
// pcc_fifo
// Small first-in first-out queue of register storage, any payload type.
// ----------------------------------------------------------------------------
module pcc_fifo #(
	parameter int  DEPTH = 4,
	parameter type T     = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	input  logic rd_en,
	output T     rd_data,
	output logic full,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/pcc_front.sv =====
// ----------------------------------------------------------------------------
// pcc_front
// Counts packet bytes and marks the checksum field bytes for the back end.
// ----------------------------------------------------------------------------
module pcc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  pcc_pkg::in_t  item,
	output pcc_pkg::cls_t cls
);

	logic [pcc_pkg::LEN_W-1:0] cnt_q;
	logic [pcc_pkg::LEN_W-1:0] len_next;

	// Saturate so that a long packet never re-enters the field window
	assign len_next = (cnt_q == pcc_pkg::LEN_SAT) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		cls.data_byte     = item.data_byte;
		cls.field_en      = (cnt_q >= 13'd8) && (cnt_q <= 13'd11);
		cls.field_sel     = cnt_q[1:0];
		cls.last_byte     = item.last_byte;
		cls.packet_length = len_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= item.last_byte ? '0 : len_next;
		end
	end

endmodule

// ===== src/pcc_back.sv =====
// ----------------------------------------------------------------------------
// pcc_back
// Runs CRC32C and Adler-32 over classified bytes and forms the packet verdict.
// ----------------------------------------------------------------------------
module pcc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  pcc_pkg::cfg_t cfg,
	input  pcc_pkg::cls_t cls,
	input  logic          cls_valid,
	output logic          cls_pop,
	input  logic          res_full,
	output logic          res_push,
	output pcc_pkg::res_t res
);

	logic [31:0] crc_q;
	logic [15:0] low_q;
	logic [15:0] high_q;
	logic [31:0] field_q;

	logic [7:0]  b;
	logic [31:0] crc_next;
	logic [16:0] low_sum;
	logic [15:0] low_next;
	logic [16:0] high_sum;
	logic [15:0] high_next;
	logic [31:0] field_next;
	logic        adv;

	logic                      valid_s1;
	logic [31:0]               crc_s1;
	logic [31:0]               adl_s1;
	logic [31:0]               field_s1;
	logic [pcc_pkg::LEN_W-1:0] len_s1;
	logic                      type_s1;

	logic [31:0] field_be;
	logic        match;
	logic        in_range;
	logic        aligned;

	assign adv     = !valid_s1 || !res_full;
	assign cls_pop = cls_valid && adv;

	// Field bytes count as zero in both sums
	assign b        = cls.field_en ? 8'd0 : cls.data_byte;
	assign crc_next = pcc_pkg::crc_table(crc_q[7:0] ^ b) ^ (crc_q >> 8);

	always_comb begin
		low_sum   = {1'b0, low_q} + {9'd0, b};
		low_next  = (low_sum >= pcc_pkg::ADLER_MOD) ?
			16'(low_sum - pcc_pkg::ADLER_MOD) : low_sum[15:0];
		high_sum  = {1'b0, high_q} + {1'b0, low_next};
		high_next = (high_sum >= pcc_pkg::ADLER_MOD) ?
			16'(high_sum - pcc_pkg::ADLER_MOD) : high_sum[15:0];
	end

	always_comb begin
		field_next = field_q;
		for (int i = 0; i < 4; i++) begin
			if (cls.field_en && (cls.field_sel == 2'(i))) begin
				field_next[8*i +: 8] = cls.data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= pcc_pkg::CRC_INIT;
			low_q    <= 16'd1;
			high_q   <= 16'd0;
			field_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cls_pop && cls.last_byte;
			if (cls_pop) begin
				if (cls.last_byte) begin
					crc_q   <= pcc_pkg::CRC_INIT;
					low_q   <= 16'd1;
					high_q  <= 16'd0;
					field_q <= '0;
				end else begin
					crc_q   <= crc_next;
					low_q   <= low_next;
					high_q  <= high_next;
					field_q <= field_next;
				end
			end
		end
	end

	// Snapshot of the finished packet, held until the result queue has room
	always_ff @(posedge clk) begin
		if (adv && cls_pop && cls.last_byte) begin
			crc_s1   <= ~crc_next;
			adl_s1   <= {high_next, low_next};
			field_s1 <= field_next;
			len_s1   <= cls.packet_length;
			type_s1  <= cfg.checksum_type;
		end
	end

	assign field_be = {field_s1[7:0], field_s1[15:8], field_s1[23:16], field_s1[31:24]};
	assign match    = (type_s1 == pcc_pkg::CK_ADLER) ? (field_be == adl_s1)
		: (field_s1 == crc_s1);
	assign in_range = (len_s1 >= cfg.min_length) && (len_s1 <= cfg.max_length)
		&& (len_s1 != pcc_pkg::LEN_SAT);
	assign aligned  = (len_s1[1:0] == 2'd0);

	assign res_push = valid_s1 && !res_full;

	always_comb begin
		res.checksum_value  = (type_s1 == pcc_pkg::CK_ADLER) ? adl_s1 : crc_s1;
		res.checksum_match  = match;
		res.length_in_range = in_range;
		res.length_aligned  = aligned;
		res.packet_good     = match && in_range && aligned;
		res.packet_length   = len_s1;
	end

endmodule

// ===== src/packet_checksum_crc32c_adler32.sv =====
// ----------------------------------------------------------------------------
// packet_checksum_crc32c_adler32
// Per-packet CRC32C or Adler-32 check and generate with length checks.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result queue has room; the table and sum update is combinational.
// The result of a packet reaches the result port once its last byte has passed
// the byte queue, the snapshot stage and the result queue, in that order.
// Reset clears both queues and all sums; registers return to CRC32C,
// minimum 16 and maximum 5552. No clearing pass is needed.
module packet_checksum_crc32c_adler32 #(
	parameter int MID_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  pcc_pkg::in_t              item,
	output logic                      empty,
	input  logic                      pop,
	output pcc_pkg::res_t             result,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [pcc_pkg::LEN_W-1:0] cfg_data
);

	pcc_pkg::cfg_t cfg_q;
	pcc_pkg::cls_t cls_w;
	pcc_pkg::cls_t cls_r;
	pcc_pkg::res_t res_w;
	logic          accept;
	logic          mid_empty;
	logic          cls_pop;
	logic          res_full;
	logic          res_push;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.checksum_type <= pcc_pkg::CK_CRC32C;
			cfg_q.min_length    <= pcc_pkg::MIN_RESET;
			cfg_q.max_length    <= pcc_pkg::MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pcc_pkg::CFG_IDX_TYPE: cfg_q.checksum_type <= cfg_data[0];
				pcc_pkg::CFG_IDX_MIN:  cfg_q.min_length    <= cfg_data;
				pcc_pkg::CFG_IDX_MAX:  cfg_q.max_length    <= cfg_data;
				default: ;
			endcase
		end
	end

	pcc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.cls    (cls_w)
	);

	pcc_fifo #(
		.DEPTH (MID_DEPTH),
		.T     (pcc_pkg::cls_t)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls_w),
		.rd_en   (cls_pop),
		.rd_data (cls_r),
		.full    (full),
		.empty   (mid_empty)
	);

	pcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cls       (cls_r),
		.cls_valid (!mid_empty),
		.cls_pop   (cls_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_w)
	);

	pcc_fifo #(
		.DEPTH (RES_DEPTH),
		.T     (pcc_pkg::res_t)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_w),
		.rd_en   (pop),
		.rd_data (result),
		.full    (res_full),
		.empty   (empty)
	);

endmodule

// ===== src/pcc_checker.sv =====
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "packet_checksum_crc32c_adler32_macros.svh"

module pcc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          empty,
	input logic          pop,
	input pcc_pkg::res_t result
);

	// A waiting result beat holds until taken
	`PCC_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(result))

	// Verdict is the conjunction of the three checks
	`PCC_ASSERT_SAME(a_good, !empty, result.packet_good == (result.checksum_match && result.length_in_range && result.length_aligned))

	// Alignment follows the reported length
	`PCC_ASSERT_SAME(a_aligned, !empty, result.length_aligned == (result.packet_length[1:0] == 2'd0))

	// A saturated length is never in range
	`PCC_ASSERT_SAME(a_sat, !empty && result.length_in_range, result.packet_length != pcc_pkg::LEN_SAT)

endmodule

bind packet_checksum_crc32c_adler32 pcc_checker u_pcc_checker (.*);

// ===== bench/packet_checksum_crc32c_adler32_tb.sv =====
// ----------------------------------------------------------------------------
// packet_checksum_crc32c_adler32_tb
// Drives packets byte by byte through the checksum block and checks every
// verdict against a cycle-free model of CRC32C and Adler-32 with the field
// capture and the length checks. A short directed table comes first, then
// random packets, mostly carrying a correct checksum field, under several
// register settings and idling patterns, with one long result hold-off.
// ----------------------------------------------------------------------------
module packet_checksum_crc32c_adler32_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] CRC32C_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;
	localparam logic [16:0] ADLER_BASE  = 17'd65521;
	localparam logic [12:0] LEN_CAP     = 13'd8191;
	localparam int          SETTLE      = 6;
	localparam int          QUIET_LIMIT = 4000;
	localparam int          HOLD_LEN    = 400;
	localparam int          PHASE_BYTES = 110;

	typedef struct {
		bit            is_cfg;
		logic [1:0]    idx;
		logic [12:0]   val;
		pcc_pkg::in_t  beat;
		bit            typed;
		pcc_pkg::res_t want;
	} stim_row_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          push      = 1'b0;
	logic          full;
	pcc_pkg::in_t  item      = '0;
	logic          empty;
	logic          pop       = 1'b0;
	pcc_pkg::res_t result;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [1:0]    cfg_index = pcc_pkg::CFG_IDX_TYPE;
	logic [12:0]   cfg_data  = '0;

	// model state
	logic [31:0] crc_acc   = CRC_SEED;
	logic [31:0] adler_acc = 32'h0000_0001;
	logic [12:0] byte_cnt  = '0;
	logic [31:0] field_acc = '0;
	logic        sel_type  = pcc_pkg::CK_CRC32C;
	logic [12:0] len_min   = pcc_pkg::MIN_RESET;
	logic [12:0] len_max   = pcc_pkg::MAX_RESET;

	pcc_pkg::res_t verdicts_due[$];
	stim_row_t     dir_rows[$];
	int            fault_count  = 0;
	int            quiet_cycles = 0;
	int            send_idle    = 0;
	int            recv_stall   = 0;
	int            hold_left    = 0;

	packet_checksum_crc32c_adler32 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// {high sum, low sum}, both reduced on every byte
	function automatic logic [31:0] adler_next(logic [31:0] s, logic [7:0] b);
		logic [16:0] lo;
		logic [16:0] hi;
		lo = s[15:0] + b;
		if (lo >= ADLER_BASE) lo = lo - ADLER_BASE;
		hi = s[31:16] + lo[15:0];
		if (hi >= ADLER_BASE) hi = hi - ADLER_BASE;
		return {hi[15:0], lo[15:0]};
	endfunction

	function automatic logic [31:0] packet_sum(logic [7:0] pk[$], logic kind);
		logic [31:0] crc;
		logic [31:0] adl;
		logic [7:0]  b;
		crc = CRC_SEED;
		adl = 32'h0000_0001;
		foreach (pk[i]) begin
			b = (i >= 8 && i <= 11) ? 8'h00 : pk[i];
			crc = crc_next(crc, b);
			adl = adler_next(adl, b);
		end
		return (kind == pcc_pkg::CK_ADLER) ? adl : ~crc;
	endfunction

	task automatic predict_verdict(input pcc_pkg::in_t beat, output bit has,
			output pcc_pkg::res_t r);
		logic [7:0]  b;
		logic [31:0] sum;
		logic [31:0] field_be;
		logic [12:0] len;
		int          pos;
		b = beat.data_byte;
		pos = byte_cnt;
		r = '0;
		if (pos >= 8 && pos <= 11) begin
			field_acc[(pos - 8) * 8 +: 8] = b;
			b = 8'h00;
		end
		crc_acc = crc_next(crc_acc, b);
		adler_acc = adler_next(adler_acc, b);
		if (byte_cnt != LEN_CAP) byte_cnt = byte_cnt + 13'd1;
		has = beat.last_byte;
		if (has) begin
			len = byte_cnt;
			if (sel_type == pcc_pkg::CK_CRC32C) begin
				sum = ~crc_acc;
				r.checksum_match = (field_acc == sum);
			end else begin
				sum = adler_acc;
				field_be = {field_acc[7:0], field_acc[15:8], field_acc[23:16], field_acc[31:24]};
				r.checksum_match = (field_be == sum);
			end
			r.checksum_value  = sum;
			r.length_in_range = (len >= len_min) && (len <= len_max) && (len != LEN_CAP);
			r.length_aligned  = (len[1:0] == 2'b00);
			r.packet_good     = r.checksum_match && r.length_in_range && r.length_aligned;
			r.packet_length   = len;
			crc_acc   = CRC_SEED;
			adler_acc = 32'h0000_0001;
			byte_cnt  = '0;
			field_acc = '0;
		end
	endtask

	function automatic void add_beat(logic [7:0] b, logic last, bit typed = 1'b0,
			pcc_pkg::res_t want = '0);
		stim_row_t r;
		r.is_cfg = 1'b0;
		r.idx    = pcc_pkg::CFG_IDX_TYPE;
		r.val    = '0;
		r.beat   = pcc_pkg::in_t'({b, last});
		r.typed  = typed;
		r.want   = want;
		dir_rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [1:0] idx, logic [12:0] val);
		stim_row_t r;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		r.beat   = '0;
		r.typed  = 1'b0;
		r.want   = '0;
		dir_rows.push_back(r);
	endfunction

	task automatic put_beat(input pcc_pkg::in_t beat, input bit typed,
			input pcc_pkg::res_t want);
		bit            took;
		bit            has;
		pcc_pkg::res_t r;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				item <= beat;
			end
			@(posedge clk);
			took = push && !full;
		end
		predict_verdict(beat, has, r);
		if (has) verdicts_due.push_back(typed ? want : r);
	endtask

	// Registers change only once the block has drained
	task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
		@(negedge clk);
		push <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			pcc_pkg::CFG_IDX_TYPE: sel_type = val[0];
			pcc_pkg::CFG_IDX_MIN:  len_min  = val;
			pcc_pkg::CFG_IDX_MAX:  len_max  = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_packet(input int n, input bit spoil);
		logic [7:0]  pk[$];
		logic [31:0] sum;
		for (int i = 0; i < n; i++) pk.push_back(8'($urandom_range(255)));
		if (n >= 12) begin
			sum = packet_sum(pk, sel_type);
			if (sel_type == pcc_pkg::CK_CRC32C) begin
				{pk[11], pk[10], pk[9], pk[8]} = sum;
			end else begin
				{pk[8], pk[9], pk[10], pk[11]} = sum;
			end
		end
		if (spoil) pk[$urandom_range(n - 1)] ^= 8'h01 << $urandom_range(7);
		for (int i = 0; i < n; i++) put_beat(pcc_pkg::in_t'({pk[i], i == n - 1}), 1'b0, '0);
	endtask

	task automatic flag_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		fault_count++;
		if (fault_count <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
	endtask

	task automatic compare_verdict(input pcc_pkg::res_t got);
		pcc_pkg::res_t want;
		if (verdicts_due.size() == 0) begin
			fault_count++;
			if (fault_count <= 10) $display("verdict with none pending: %h", got);
		end else begin
			want = verdicts_due.pop_front();
			if (got.checksum_value !== want.checksum_value)
				flag_field("checksum_value", want.checksum_value, got.checksum_value);
			if (got.checksum_match !== want.checksum_match)
				flag_field("checksum_match", want.checksum_match, got.checksum_match);
			if (got.length_in_range !== want.length_in_range)
				flag_field("length_in_range", want.length_in_range, got.length_in_range);
			if (got.length_aligned !== want.length_aligned)
				flag_field("length_aligned", want.length_aligned, got.length_aligned);
			if (got.packet_good !== want.packet_good)
				flag_field("packet_good", want.packet_good, got.packet_good);
			if (got.packet_length !== want.packet_length)
				flag_field("packet_length", want.packet_length, got.packet_length);
		end
	endtask

	// Result side: random stalls, plus one long hold-off on request
	always begin
		@(negedge clk);
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall);
		end
		@(posedge clk);
		if (arst_n && pop && !empty) compare_verdict(result);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int          k;
		int          n;
		int          sent;
		int          pick;
		logic        ty;
		logic [12:0] mn;
		logic [12:0] mx;

		// single bytes after reset, CRC32C then Adler-32
		add_beat(8'h00, 1'b1, 1'b1, {32'h527D_5351, 4'b0000, 13'd1});
		add_beat(8'hFF, 1'b1, 1'b1, {32'hFF00_0000, 4'b0000, 13'd1});
		add_cfg(pcc_pkg::CFG_IDX_TYPE, 13'(pcc_pkg::CK_ADLER));
		add_beat(8'h00, 1'b1, 1'b1, {32'h0001_0001, 4'b0000, 13'd1});
		add_beat(8'hFF, 1'b1, 1'b1, {32'h0100_0100, 4'b0000, 13'd1});
		// packet ending inside the checksum field
		add_beat(8'h01, 1'b0);
		add_beat(8'h02, 1'b0);
		add_beat(8'h04, 1'b0);
		add_beat(8'h08, 1'b0);
		add_beat(8'h10, 1'b0);
		add_beat(8'h20, 1'b0);
		add_beat(8'h40, 1'b0);
		add_beat(8'h80, 1'b0);
		add_beat(8'hAA, 1'b0);
		add_beat(8'h55, 1'b1);
		// selection switched part way through a packet
		add_beat(8'hC3, 1'b0);
		add_beat(8'h3C, 1'b0);
		add_beat(8'h5A, 1'b0);
		add_cfg(pcc_pkg::CFG_IDX_TYPE, 13'(pcc_pkg::CK_CRC32C));
		add_beat(8'hA5, 1'b1);
		// minimum above maximum, then the widest window
		add_cfg(pcc_pkg::CFG_IDX_MIN, 13'd8191);
		add_cfg(pcc_pkg::CFG_IDX_MAX, 13'd0);
		add_beat(8'h7F, 1'b1);
		add_cfg(pcc_pkg::CFG_IDX_MIN, 13'd0);
		add_cfg(pcc_pkg::CFG_IDX_MAX, 13'd8191);
		add_beat(8'h80, 1'b1);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle  = 20;
		recv_stall = 20;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) write_reg(dir_rows[i].idx, dir_rows[i].val);
			else put_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 64; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 64; end
				default: begin send_idle = 36; recv_stall = 36; end
			endcase
			for (int j = 0; j < 2; j++) begin
				k = 2 * p + j;
				case (k)
					0: begin ty = pcc_pkg::CK_CRC32C; mn = 13'd0;    mx = 13'd8191; end
					1: begin ty = pcc_pkg::CK_ADLER;  mn = 13'd12;   mx = 13'd40;   end
					2: begin ty = pcc_pkg::CK_ADLER;  mn = 13'd8191; mx = 13'd0;    end
					3: begin ty = pcc_pkg::CK_CRC32C; mn = 13'd16;   mx = 13'd5552; end
					4: begin ty = pcc_pkg::CK_ADLER;  mn = 13'd1;    mx = 13'd8191; end
					5: begin
						ty = pcc_pkg::CK_CRC32C;
						mn = 13'($urandom_range(20));
						mx = 13'($urandom_range(60, 20));
					end
					6: begin
						ty = 1'($urandom_range(1));
						mn = 13'($urandom_range(30));
						mx = 13'($urandom_range(8191, 8));
					end
					default: begin ty = pcc_pkg::CK_CRC32C; mn = 13'd4; mx = 13'd24; end
				endcase
				write_reg(pcc_pkg::CFG_IDX_TYPE, 13'(ty));
				write_reg(pcc_pkg::CFG_IDX_MIN, mn);
				write_reg(pcc_pkg::CFG_IDX_MAX, mx);
				// hold results back while short packets pile up behind them
				if (k == 0) hold_left = HOLD_LEN;
				sent = 0;
				while (sent < PHASE_BYTES) begin
					pick = $urandom_range(99);
					if (k == 0) n = $urandom_range(6, 1);
					else if (pick < 30) n = $urandom_range(11, 1);
					else if (pick < 85) n = $urandom_range(24, 12);
					else n = $urandom_range(64, 25);
					if ($urandom_range(1) == 1) n = (n + 3) & ~3;
					send_packet(n, $urandom_range(99) < 25);
					sent += n;
				end
			end
		end

		@(negedge clk);
		push <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE * 2) @(posedge clk);
		if (fault_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
